@@ src/mltt_pkg.sv @@
`default_nettype none

package mltt_pkg;

  // Field widths fixed by the interface
  localparam int TEMP_W  = 18;
  localparam int HYST_W  = 16;
  localparam int LVL_W   = 3;
  localparam int CFG_W   = 34;
  localparam int IDX_W   = 3;
  localparam int THR_W   = TEMP_W + 2;

  // Default number of trip levels
  localparam int NUM_LEVELS_DEF = 4;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_LEVEL0     = 3'd0,
    REG_LEVEL1     = 3'd1,
    REG_LEVEL2     = 3'd2,
    REG_LEVEL3     = 3'd3,
    REG_LEVELS_USE = 3'd4,
    REG_MAX_LEVEL  = 3'd5
  } cfg_reg_t;

  // One level setting: hysteresis above the signed trip temperature
  typedef struct packed {
    logic        [HYST_W-1:0] hyst;
    logic signed [TEMP_W-1:0] trip;
  } setting_t;

  // Control registers that steer the level search
  typedef struct packed {
    logic [LVL_W-1:0] levels_in_use;
    logic [LVL_W-1:0] max_level;
  } cfg_ctl_t;

  // Result of one sample
  typedef struct packed {
    logic             rising;
    logic             changed;
    logic [LVL_W-1:0] level;
  } result_t;

  localparam setting_t SETTING_RESET = '{hyst: '0, trip: 18'sd131071};
  localparam logic [LVL_W-1:0] LEVELS_RESET = 3'd4;
  localparam logic [LVL_W-1:0] MAX_RESET    = 3'd4;

endpackage

`default_nettype wire

@@ src/mltt_cfg_regs.sv @@
`default_nettype none

module mltt_cfg_regs #(
  parameter int NUM_LEVELS = mltt_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mltt_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [mltt_pkg::CFG_W-1:0]  cfg_data,
  output mltt_pkg::setting_t               settings [NUM_LEVELS],
  output mltt_pkg::cfg_ctl_t               ctl
);
  import mltt_pkg::*;

  setting_t settings_r [NUM_LEVELS];
  cfg_ctl_t ctl_r;
  logic     wr_en;

  // Writes are always taken; indexes past the list are dropped
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  // Level settings; those beyond the built level count are not stored
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_setting
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        settings_r[g] <= SETTING_RESET;
      end else if (wr_en && cfg_index == IDX_W'(g)) begin
        settings_r[g] <= setting_t'(cfg_data);
      end
    end
    assign settings[g] = settings_r[g];
  end

  // Level count and clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.levels_in_use <= LEVELS_RESET;
      ctl_r.max_level     <= MAX_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEVELS_USE: ctl_r.levels_in_use <= cfg_data[LVL_W-1:0];
        REG_MAX_LEVEL:  ctl_r.max_level     <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign ctl = ctl_r;

endmodule

`default_nettype wire

@@ src/mltt_step.sv @@
`default_nettype none

module mltt_step #(
  parameter int NUM_LEVELS = mltt_pkg::NUM_LEVELS_DEF
) (
  input  wire logic signed [mltt_pkg::TEMP_W-1:0] temperature,
  input  wire logic        [mltt_pkg::LVL_W-1:0]  cur_level,
  input  mltt_pkg::setting_t                      settings [NUM_LEVELS],
  input  mltt_pkg::cfg_ctl_t                      ctl,
  output mltt_pkg::result_t                       result
);
  import mltt_pkg::*;

  localparam int K_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  logic        [LVL_W-1:0] used;
  logic        [LVL_W-1:0] target;
  logic        [LVL_W-1:0] clamped;
  logic        [LVL_W-1:0] k_full;
  logic        [K_W-1:0]   k;
  logic signed [THR_W-1:0] release_thr;
  logic signed [THR_W-1:0] temp_ext;
  logic                    release_ok;
  logic        [LVL_W-1:0] next_level;

  // Number of settings that take part in the search
  assign used = (ctl.levels_in_use > LVL_W'(NUM_LEVELS)) ? LVL_W'(NUM_LEVELS)
                                                         : ctl.levels_in_use;

  // Highest level whose trip has been reached, clamped
  always_comb begin
    target = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (LVL_W'(i) < used && temperature >= settings[i].trip) begin
        target = LVL_W'(i + 1);
      end
    end
    clamped = (target > ctl.max_level) ? ctl.max_level : target;
  end

  // Release threshold of the current level: trip minus hysteresis
  assign k_full      = cur_level - LVL_W'(1);
  assign k           = k_full[K_W-1:0];
  assign temp_ext    = THR_W'(temperature);
  assign release_thr = THR_W'(settings[k].trip)
                       - $signed({{(THR_W-HYST_W){1'b0}}, settings[k].hyst});
  assign release_ok  = temp_ext <= release_thr;

  // Rise at once, fall only past the hysteresis band
  always_comb begin
    next_level = cur_level;
    if (clamped > cur_level) begin
      next_level = clamped;
    end else if (clamped < cur_level && release_ok) begin
      next_level = clamped;
    end
    result.level   = next_level;
    result.changed = next_level != cur_level;
    result.rising  = next_level > cur_level;
  end

endmodule

`default_nettype wire

@@ src/multi_level_thermal_throttle.sv @@
`default_nettype none

// Step-wise thermal governor with hysteresis.
// Samples arrive on the in_ stream: in_tdata[17:0] is a signed temperature in
// millidegrees. Each sample gives one result on the out_ stream: the throttle
// level, a changed flag and a rising flag.
// Trip and hysteresis values, the number of levels in use and the level clamp
// are written through the cfg_ port (always ready). The user must write them only
// while the block is idle; the block itself does not enforce this.
// The level search and hysteresis test run between the input and result registers.
// Throughput: one sample per clock while the receiver takes results; the current
// level is updated in the same cycle that the result register is loaded, so
// samples may follow back to back.
// When the receiver stalls the result holds, the input register still takes
// one more sample, and in_tready falls only once both registers are full.
// Reset clears the level to 0, empties both registers and restores the
// default settings (trip 131071, no hysteresis, four levels, clamp four).
module multi_level_thermal_throttle #(
  parameter int NUM_LEVELS = mltt_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Sample stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mltt_pkg::IN_DATA_W-1:0]  in_tdata,  // [17:0] temperature
  // Result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mltt_pkg::OUT_DATA_W-1:0]      out_tdata, // [2:0] level, [3] changed,
                                                          // [4] rising
  // Configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mltt_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [mltt_pkg::CFG_W-1:0]      cfg_data
);
  import mltt_pkg::*;

  setting_t                settings [NUM_LEVELS];
  cfg_ctl_t                ctl;
  result_t                 result;

  logic                    in_valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic        [LVL_W-1:0] level_r;
  logic                    out_valid_r;
  result_t                 out_data_r;
  logic                    advance;

  mltt_cfg_regs #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .settings  (settings),
    .ctl       (ctl)
  );

  mltt_step #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_step (
    .temperature (temp_r),
    .cur_level   (level_r),
    .settings    (settings),
    .ctl         (ctl),
    .result      (result)
  );

  // The held sample moves on when the result register is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      temp_r <= $signed(in_tdata[TEMP_W-1:0]);
    end
  end

  // Current level, updated as each result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (advance) begin
      level_r <= result.level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_data_r};

endmodule

`default_nettype wire

@@ tb/multi_level_thermal_throttle_tb.sv @@
`timescale 1ns / 1ps

module multi_level_thermal_throttle_tb;
  import mltt_pkg::*;

  localparam int NUM_LVL       = NUM_LEVELS_DEF;
  localparam int MAX_GAP       = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 110;
  localparam int TEMP_MIN      = -131072;
  localparam int TEMP_MAX      = 131071;

  // Register indexes outside the map; writes to them must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [17:0] temperature
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [2:0] level, [3] changed, [4] rising
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  // Own copy of the governor state and its settings
  int trip_mdeg[4];
  int hyst_mdeg[4];
  int levels_used;
  int level_cap;
  int throttle_now;

  int      pending_temps[$];
  result_t expected_levels[$];

  bit calm      = 1'b0;
  bit hold_go   = 1'b0;
  int hold_left = 0;
  int gap_left  = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int samples_in = 0;
  int results_seen = 0;
  int cfg_writes = 0;

  multi_level_thermal_throttle #(
    .NUM_LEVELS(NUM_LVL)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Step-wise level update with hysteresis on the way down.
  function automatic result_t throttle_step(input logic [TEMP_W-1:0] raw);
    int      t;
    int      used;
    int      target;
    int      prior;
    int      k;
    result_t r;
    t      = $signed(raw);
    used   = (levels_used > NUM_LVL) ? NUM_LVL : levels_used;
    target = 0;
    prior  = throttle_now;
    for (int i = 0; i < used; i++) begin
      if (t >= trip_mdeg[i]) target = i + 1;
    end
    if (target > level_cap) target = level_cap;
    if (target > prior) begin
      throttle_now = target;
    end else if (target < prior) begin
      // The release test always uses the setting of the level being left.
      k = prior - 1;
      if (t <= trip_mdeg[k] - hyst_mdeg[k]) throttle_now = target;
    end
    r.level   = LVL_W'(throttle_now);
    r.changed = (throttle_now != prior);
    r.rising  = (throttle_now > prior);
    return r;
  endfunction

  // Mostly samples around a trip's hysteresis band, sometimes anywhere.
  function automatic int rand_temp();
    int j;
    int t;
    j = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) begin
      t = int'($urandom_range(0, 262143)) + TEMP_MIN;
    end else begin
      t = trip_mdeg[j] - hyst_mdeg[j] - 64 + int'($urandom_range(0, 2 * hyst_mdeg[j] + 128));
    end
    if (t > TEMP_MAX) t = TEMP_MAX;
    if (t < TEMP_MIN) t = TEMP_MIN;
    return t;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // One register write transaction; the copy is updated once it is taken.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    setting_t s;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_LEVEL0, REG_LEVEL1, REG_LEVEL2, REG_LEVEL3: begin
        s              = val;
        trip_mdeg[idx] = $signed(s.trip);
        hyst_mdeg[idx] = s.hyst;
      end
      REG_LEVELS_USE: levels_used = val[LVL_W-1:0];
      REG_MAX_LEVEL:  level_cap   = val[LVL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_setting(input int lvl, input int trip, input int hyst);
    setting_t s;
    s.trip = TEMP_W'(trip);
    s.hyst = HYST_W'(hyst);
    write_reg(IDX_W'(REG_LEVEL0 + lvl), s);
  endtask

  // Wait until every sample has been taken and answered, then let the
  // two pipeline stages empty before anything is reconfigured.
  task automatic drain();
    @(negedge clk);
    while (pending_temps.size() != 0 || in_tvalid || expected_levels.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sample driver: offers queued temperatures with a random gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_levels.push_back(throttle_step(in_tdata[TEMP_W-1:0]));
        samples_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (pending_temps.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_DATA_W - TEMP_W){1'b0}}, TEMP_W'(pending_temps.pop_front())};
          gap_left  <= calm ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[LVL_W+1:0];
        results_seen++;
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected result, expected none, got level %0d changed %0d rising %0d",
                   $time, got.level, got.changed, got.rising);
          errors++;
        end else begin
          want = expected_levels.pop_front();
          compare_field("level", want.level, got.level);
          compare_field("changed", want.changed, got.changed);
          compare_field("rising", want.rising, got.rising);
        end
        stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_tready <= (hold_left == 0) && (stall_left == 0);
    end
  end

  // Long receiver hold-off, counted here so the monitor only tests the count for zero.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] raw;
    int               t;
    int               n;
    for (int i = 0; i < 4; i++) begin
      trip_mdeg[i] = $signed(SETTING_RESET.trip);
      hyst_mdeg[i] = SETTING_RESET.hyst;
    end
    levels_used  = LEVELS_RESET;
    level_cap    = MAX_RESET;
    throttle_now = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: only the very top of the range trips anything.
    @(negedge clk);
    pending_temps = '{TEMP_MIN, -1, 0, TEMP_MAX, TEMP_MAX - 1, TEMP_MAX};
    drain();

    // Ordinary ascending trips with hysteresis: rises, holds and releases.
    write_setting(0, 10000, 2000);
    write_setting(1, 20000, 3000);
    write_setting(2, 30000, 4000);
    write_setting(3, 40000, 5000);
    write_reg(REG_LEVELS_USE, CFG_W'(4));
    write_reg(REG_MAX_LEVEL, CFG_W'(4));
    @(negedge clk);
    pending_temps = '{25000, 19000, 17000, 45000, 0, 36000, 35000};
    drain();

    // Fewer levels in use than the current level: release uses level three.
    write_reg(REG_LEVELS_USE, CFG_W'(1));
    @(negedge clk);
    pending_temps = '{28000, 26000};
    drain();

    // Clamp of zero forces the target down, hysteresis still applies.
    write_reg(REG_MAX_LEVEL, CFG_W'(0));
    @(negedge clk);
    pending_temps = '{50000, 8000};
    drain();

    // Level count and clamp above the number of levels.
    write_reg(REG_LEVELS_USE, CFG_W'(7));
    write_reg(REG_MAX_LEVEL, CFG_W'(7));
    @(negedge clk);
    pending_temps = '{TEMP_MAX};
    drain();

    // Lowest possible release threshold, an all-ones setting, writes to the
    // unused indexes, and no levels in use at all.
    write_setting(3, TEMP_MIN, 65535);
    write_reg(REG_LEVEL2, '1);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    @(negedge clk);
    pending_temps = '{TEMP_MIN, 0};
    drain();
    write_reg(REG_LEVELS_USE, CFG_W'(0));
    @(negedge clk);
    pending_temps = '{TEMP_MIN, TEMP_MAX};
    drain();

    // Random settings, each followed by a burst of samples.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      t = TEMP_MIN + int'($urandom_range(0, 150000));
      for (int i = 0; i < 4; i++) begin
        if (p % 4 != 3) begin
          write_setting(i, t, $urandom_range(0, 1) ? $urandom_range(0, 4000)
                                                   : $urandom_range(0, 65535));
          t = t + int'($urandom_range(0, 50000));
          if (t > TEMP_MAX) t = TEMP_MAX;
        end else begin
          raw = CFG_W'({$urandom, $urandom});
          write_reg(IDX_W'(REG_LEVEL0 + i), raw);
        end
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      write_reg(REG_LEVELS_USE, CFG_W'(n));
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      write_reg(REG_MAX_LEVEL, CFG_W'(n));
      if ($urandom_range(0, 2) == 0) begin
        raw = CFG_W'({$urandom, $urandom});
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, raw);
      end
      @(negedge clk);
      calm = (p % 3 == 1);
      repeat (PHASE_ITEMS) pending_temps.push_back(rand_temp());
      if (p == 4) begin
        // Sender keeps offering while the receiver holds off.
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
      end
      drain();
    end

    $display("summary: %0d samples in, %0d results checked, %0d register writes",
             samples_in, results_seen, cfg_writes);
    $display("summary: %0d register settings, random gaps on both streams, one long stall",
             RANDOM_PHASES + 7);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mltt_pkg.sv
src/mltt_cfg_regs.sv
src/mltt_step.sv
src/multi_level_thermal_throttle.sv
tb/multi_level_thermal_throttle_tb.sv
